FILE: hw/rtl/wtalu_pkg.sv
// Shared types, constants and helper functions of the width-typed integer ALU.
package wtalu_pkg;

    localparam int unsigned DATA_W  = 64;
    localparam int unsigned WIDTH_W = 7;
    localparam int unsigned DIV_STAGES = DATA_W;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_MUL  = 5'd2,
        OP_UDIV = 5'd3,
        OP_UREM = 5'd4,
        OP_SDIV = 5'd5,
        OP_SREM = 5'd6,
        OP_AND  = 5'd7,
        OP_OR   = 5'd8,
        OP_XOR  = 5'd9,
        OP_SHL  = 5'd10,
        OP_LSHR = 5'd11,
        OP_ASHR = 5'd12,
        OP_EQ   = 5'd13,
        OP_NE   = 5'd14,
        OP_ULT  = 5'd15,
        OP_ULE  = 5'd16,
        OP_UGT  = 5'd17,
        OP_UGE  = 5'd18,
        OP_SLT  = 5'd19,
        OP_SLE  = 5'd20,
        OP_SGT  = 5'd21,
        OP_SGE  = 5'd22
    } mode_t;

    typedef enum logic [2:0] {
        TYPE_I1  = 3'd0,
        TYPE_I8  = 3'd1,
        TYPE_I16 = 3'd2,
        TYPE_I32 = 3'd3,
        TYPE_I64 = 3'd4,
        TYPE_PTR = 3'd5
    } type_code_t;

    localparam logic [0:0] REG_POINTER_WIDTH = 1'b0;

    // Side information that travels with each item down the pipeline.
    typedef struct packed {
        mode_t               mode;
        logic [WIDTH_W-1:0]  width;
        logic                ok;
        logic                neg;
        logic [DATA_W-1:0]   simple;
    } item_t;

    // Working state of the restoring divider.
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] divisor;
    } div_t;

    function automatic logic [DATA_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
        logic [DATA_W-1:0] m;
        if (w >= WIDTH_W'(DATA_W)) begin
            m = '1;
        end
        else begin
            m = ~({DATA_W{1'b1}} << w);
        end
        return m;
    endfunction

endpackage

FILE: hw/rtl/wtalu_front.sv
// Front end: operand normalisation, simple operations, partial products and divider set-up.
module wtalu_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [4:0]                        mode,
    input  logic [2:0]                        type_code,
    input  logic [63:0]                       operand_a,
    input  logic [63:0]                       operand_b,
    input  logic [wtalu_pkg::WIDTH_W-1:0]     pointer_width,
    output logic                              out_valid,
    output wtalu_pkg::item_t                  out_item,
    output wtalu_pkg::div_t                   out_div
);

    logic [wtalu_pkg::WIDTH_W-1:0] w;
    logic [63:0] mask, ua, ub, sa, sb, simple, dividend, divisor;
    logic        sign_a, sign_b, ok, neg, shift_bad;
    wtalu_pkg::mode_t op;

    logic             s1_valid_reg, s1_valid_next;
    wtalu_pkg::item_t s1_item_reg, s1_item_next;
    logic [63:0]      s1_ll_reg, s1_ll_next;
    logic [31:0]      s1_lh_reg, s1_lh_next, s1_hl_reg, s1_hl_next;
    logic [63:0]      s1_dvd_reg, s1_dvd_next, s1_dvs_reg, s1_dvs_next;

    logic             s2_valid_reg, s2_valid_next;
    wtalu_pkg::item_t s2_item_reg, s2_item_next;
    wtalu_pkg::div_t  s2_div_reg, s2_div_next;

    assign op = wtalu_pkg::mode_t'(mode);

    always_comb
    begin
        unique case (wtalu_pkg::type_code_t'(type_code))
            wtalu_pkg::TYPE_I1:  w = 7'd1;
            wtalu_pkg::TYPE_I8:  w = 7'd8;
            wtalu_pkg::TYPE_I16: w = 7'd16;
            wtalu_pkg::TYPE_I32: w = 7'd32;
            wtalu_pkg::TYPE_PTR:
                w = (pointer_width == 7'd0 || pointer_width > 7'd64) ? 7'd64 : pointer_width;
            default:             w = 7'd64;
        endcase
    end

    always_comb
    begin
        mask   = wtalu_pkg::width_mask(w);
        ua     = operand_a & mask;
        ub     = operand_b & mask;
        sign_a = operand_a[6'(w - 7'd1)];
        sign_b = operand_b[6'(w - 7'd1)];
        sa     = ua | (sign_a ? ~mask : 64'd0);
        sb     = ub | (sign_b ? ~mask : 64'd0);
        shift_bad = (ub >= {57'd0, w});
    end

    always_comb
    begin
        simple   = 64'd0;
        ok       = 1'b1;
        neg      = 1'b0;
        dividend = ua;
        divisor  = ub;
        unique case (op)
            wtalu_pkg::OP_ADD:  simple = ua + ub;
            wtalu_pkg::OP_SUB:  simple = ua - ub;
            wtalu_pkg::OP_MUL:  simple = 64'd0;
            wtalu_pkg::OP_UDIV,
            wtalu_pkg::OP_UREM: ok = (ub != 64'd0);
            wtalu_pkg::OP_SDIV,
            wtalu_pkg::OP_SREM:
            begin
                ok = !(sb == 64'd0 || (sa == 64'h8000_0000_0000_0000 && sb == '1));
                dividend = sa[63] ? (64'd0 - sa) : sa;
                divisor  = sb[63] ? (64'd0 - sb) : sb;
                neg = (op == wtalu_pkg::OP_SDIV) ? (sa[63] ^ sb[63]) : sa[63];
            end
            wtalu_pkg::OP_AND:  simple = ua & ub;
            wtalu_pkg::OP_OR:   simple = ua | ub;
            wtalu_pkg::OP_XOR:  simple = ua ^ ub;
            wtalu_pkg::OP_SHL:
            begin
                ok = !shift_bad;
                simple = ua << ub[5:0];
            end
            wtalu_pkg::OP_LSHR:
            begin
                ok = !shift_bad;
                simple = ua >> ub[5:0];
            end
            wtalu_pkg::OP_ASHR:
            begin
                ok = !shift_bad;
                simple = 64'($signed(sa) >>> ub[5:0]);
            end
            wtalu_pkg::OP_EQ:   simple = {63'd0, ua == ub};
            wtalu_pkg::OP_NE:   simple = {63'd0, ua != ub};
            wtalu_pkg::OP_ULT:  simple = {63'd0, ua < ub};
            wtalu_pkg::OP_ULE:  simple = {63'd0, ua <= ub};
            wtalu_pkg::OP_UGT:  simple = {63'd0, ua > ub};
            wtalu_pkg::OP_UGE:  simple = {63'd0, ua >= ub};
            wtalu_pkg::OP_SLT:  simple = {63'd0, $signed(sa) < $signed(sb)};
            wtalu_pkg::OP_SLE:  simple = {63'd0, $signed(sa) <= $signed(sb)};
            wtalu_pkg::OP_SGT:  simple = {63'd0, $signed(sa) > $signed(sb)};
            wtalu_pkg::OP_SGE:  simple = {63'd0, $signed(sa) >= $signed(sb)};
            default:            ok = 1'b0;
        endcase
    end

    always_comb
    begin
        s1_valid_next      = in_valid;
        s1_item_next.mode  = op;
        s1_item_next.width = w;
        s1_item_next.ok    = ok;
        s1_item_next.neg   = neg;
        s1_item_next.simple = simple;
        s1_ll_next  = {32'd0, ua[31:0]} * {32'd0, ub[31:0]};
        s1_lh_next  = 32'(ua[31:0] * ub[63:32]);
        s1_hl_next  = 32'(ua[63:32] * ub[31:0]);
        s1_dvd_next = dividend;
        s1_dvs_next = divisor;
    end

    // Second stage sums the partial products and loads the divider.
    always_comb
    begin
        s2_valid_next = s1_valid_reg;
        s2_item_next  = s1_item_reg;
        if (s1_item_reg.mode == wtalu_pkg::OP_MUL) begin
            s2_item_next.simple = s1_ll_reg + {s1_lh_reg + s1_hl_reg, 32'd0};
        end
        s2_div_next.rem     = 64'd0;
        s2_div_next.quo     = s1_dvd_reg;
        s2_div_next.divisor = s1_dvs_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en) begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            s1_item_reg <= s1_item_next;
            s1_ll_reg   <= s1_ll_next;
            s1_lh_reg   <= s1_lh_next;
            s1_hl_reg   <= s1_hl_next;
            s1_dvd_reg  <= s1_dvd_next;
            s1_dvs_reg  <= s1_dvs_next;
            s2_item_reg <= s2_item_next;
            s2_div_reg  <= s2_div_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;
    assign out_div   = s2_div_reg;

endmodule

FILE: hw/rtl/wtalu_div_stage.sv
// One restoring division step: a single quotient bit per register stage.
module wtalu_div_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  wtalu_pkg::item_t  in_item,
    input  wtalu_pkg::div_t   in_div,
    output logic              out_valid,
    output wtalu_pkg::item_t  out_item,
    output wtalu_pkg::div_t   out_div
);

    logic [64:0]      trial;
    logic [64:0]      diff;
    logic             valid_reg;
    wtalu_pkg::item_t item_reg;
    wtalu_pkg::div_t  div_reg, div_next;

    always_comb
    begin
        trial = {in_div.rem, in_div.quo[63]};
        diff  = trial - {1'b0, in_div.divisor};
        div_next.divisor = in_div.divisor;
        if (!diff[64]) begin
            div_next.rem = diff[63:0];
            div_next.quo = {in_div.quo[62:0], 1'b1};
        end
        else begin
            div_next.rem = trial[63:0];
            div_next.quo = {in_div.quo[62:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            item_reg <= in_item;
            div_reg  <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_div   = div_reg;

endmodule

FILE: hw/rtl/wtalu_back.sv
// Back end: selects quotient, remainder or simple result; sign fix, truncation and output register.
module wtalu_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  wtalu_pkg::item_t  in_item,
    input  wtalu_pkg::div_t   in_div,
    output logic              out_valid,
    output logic [63:0]       result_value,
    output logic              foldable
);

    logic [63:0] r;
    logic        valid_reg;
    logic [63:0] result_reg, result_next;
    logic        ok_reg;

    always_comb
    begin
        unique case (in_item.mode)
            wtalu_pkg::OP_UDIV, wtalu_pkg::OP_SDIV: r = in_div.quo;
            wtalu_pkg::OP_UREM, wtalu_pkg::OP_SREM: r = in_div.rem;
            default:                                r = in_item.simple;
        endcase
        if (in_item.neg) begin
            r = 64'd0 - r;
        end
        result_next = in_item.ok ? (r & wtalu_pkg::width_mask(in_item.width)) : 64'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            result_reg <= result_next;
            ok_reg     <= in_item.ok;
        end
    end

    assign out_valid    = valid_reg;
    assign result_value = result_reg;
    assign foldable     = ok_reg;

endmodule

FILE: hw/rtl/width_typed_integer_alu_fold.sv
// Top level of the width-typed integer ALU with folding guard.
// The pipeline has two front stages, one stage per quotient bit of the 64-bit
// restoring divider, and one output stage.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken.
// Reset clears every valid bit and sets pointer_width to 64.
module width_typed_integer_alu_fold (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  mode,
    input  logic [2:0]  type_code,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_value,
    output logic        foldable,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // One global enable moves every stage at once, so a stall neither drops
    // nor duplicates a transfer.
    logic en;
    logic [wtalu_pkg::WIDTH_W-1:0] ptr_width_reg, ptr_width_next;

    logic             stg_valid [wtalu_pkg::DIV_STAGES+1];
    wtalu_pkg::item_t stg_item  [wtalu_pkg::DIV_STAGES+1];
    wtalu_pkg::div_t  stg_div   [wtalu_pkg::DIV_STAGES+1];

    assign en       = !out_valid || out_ready;
    assign in_ready = en;
    assign pready   = 1'b1;
    assign prdata   = {25'd0, ptr_width_reg};

    // The only register sits at word index zero; writes elsewhere are ignored and every read returns it.
    always_comb
    begin
        ptr_width_next = ptr_width_reg;
        if (psel && penable && pwrite && paddr[2] == wtalu_pkg::REG_POINTER_WIDTH) begin
            ptr_width_next = pwdata[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ptr_width_reg <= 7'd64;
        end
        else begin
            ptr_width_reg <= ptr_width_next;
        end
    end

    wtalu_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (in_valid),
        .mode          (mode),
        .type_code     (type_code),
        .operand_a     (operand_a),
        .operand_b     (operand_b),
        .pointer_width (ptr_width_reg),
        .out_valid     (stg_valid[0]),
        .out_item      (stg_item[0]),
        .out_div       (stg_div[0])
    );

    // Each divider stage resolves one quotient bit, most significant first.
    for (genvar k = 0; k < wtalu_pkg::DIV_STAGES; k++) begin : g_div
        wtalu_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stg_valid[k]),
            .in_item   (stg_item[k]),
            .in_div    (stg_div[k]),
            .out_valid (stg_valid[k+1]),
            .out_item  (stg_item[k+1]),
            .out_div   (stg_div[k+1])
        );
    end

    wtalu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (stg_valid[wtalu_pkg::DIV_STAGES]),
        .in_item      (stg_item[wtalu_pkg::DIV_STAGES]),
        .in_div       (stg_div[wtalu_pkg::DIV_STAGES]),
        .out_valid    (out_valid),
        .result_value (result_value),
        .foldable     (foldable)
    );

`ifndef NO_ASSERTIONS
    a_refused_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !foldable |-> result_value == 64'd0)
        else $error("refused fold carries a non-zero result");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(foldable))
        else $error("stalled result changed");

    a_ptr_write: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[2] == wtalu_pkg::REG_POINTER_WIDTH
        |=> prdata[6:0] == $past(pwdata[6:0]))
        else $error("pointer width write lost");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the width-typed integer ALU with folding guard.
module testbench;

    // One pending result: the value and the fold flag that the block should give.
    typedef struct {
        logic [63:0] value;
        logic        fold_ok;
    } fold_result_t;

    // One row of the directed table. A row with has_known set carries the
    // result typed in by hand; the other rows are checked by the predictor.
    typedef struct {
        logic [4:0]  op;
        logic [2:0]  tcode;
        logic [63:0] a;
        logic [63:0] b;
        bit          has_known;
        logic [63:0] known_value;
        logic        known_fold;
    } directed_row_t;

    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ALL1  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [4:0]  OP_UNKNOWN = 5'd31;
    localparam int unsigned LATENCY = 67;
    localparam longint unsigned CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [4:0]  mode;
    logic [2:0]  type_code;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] result_value;
    logic        foldable;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // The predictor's copy of the one configuration register.
    logic [6:0] ptr_width_shadow;

    fold_result_t pending_results[$];
    int unsigned  mismatch_count;
    longint unsigned cycle_count = 0;

    // Percentages of idle cycles for sender and receiver in the current phase.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    width_typed_integer_alu_fold dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .type_code    (type_code),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .foldable     (foldable),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #6 clk = ~clk;

    // Bit width that a type code selects, taking the pointer register into
    // account. Odd pointer widths of zero or above 64 fall back to 64.
    function automatic int unsigned type_width(input logic [2:0] tcode);
        int unsigned w;
        case (tcode)
            wtalu_pkg::TYPE_I1:  w = 1;
            wtalu_pkg::TYPE_I8:  w = 8;
            wtalu_pkg::TYPE_I16: w = 16;
            wtalu_pkg::TYPE_I32: w = 32;
            wtalu_pkg::TYPE_PTR: w = (ptr_width_shadow == 0 || ptr_width_shadow > 64) ?
                                     64 : ptr_width_shadow;
            default:  w = 64;
        endcase
        return w;
    endfunction

    function automatic logic [63:0] zero_ext(input logic [63:0] v, input int unsigned w);
        return (w >= 64) ? v : (v & ~(ALL1 << w));
    endfunction

    function automatic logic [63:0] sign_ext(input logic [63:0] v, input int unsigned w);
        logic [63:0] m;
        logic [63:0] r;
        if (w >= 64)
        begin
            return v;
        end
        m = ~(ALL1 << w);
        r = v & m;
        if (r[w-1])
        begin
            r = r | ~m;
        end
        return r;
    endfunction

    // Computes the folded value and the fold flag for one operation.
    function automatic fold_result_t fold_operation(input logic [4:0] op,
                                                    input logic [2:0] tcode,
                                                    input logic [63:0] a,
                                                    input logic [63:0] b);
        fold_result_t res;
        int unsigned w;
        logic [63:0] ua;
        logic [63:0] ub;
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        logic [63:0] r;
        logic ok;
        w  = type_width(tcode);
        ua = zero_ext(a, w);
        ub = zero_ext(b, w);
        sa = sign_ext(a, w);
        sb = sign_ext(b, w);
        r  = '0;
        ok = 1'b1;
        case (op)
            wtalu_pkg::OP_ADD:  r = ua + ub;
            wtalu_pkg::OP_SUB:  r = ua - ub;
            wtalu_pkg::OP_MUL:  r = ua * ub;
            wtalu_pkg::OP_UDIV: if (ub == 0) ok = 1'b0; else r = ua / ub;
            wtalu_pkg::OP_UREM: if (ub == 0) ok = 1'b0; else r = ua % ub;
            wtalu_pkg::OP_SDIV, wtalu_pkg::OP_SREM:
            begin
                // Division by zero is refused, and of the overflows only the full-width minimum over minus one.
                if (sb == 0 || (sa == MIN64 && sb == ALL1))
                begin
                    ok = 1'b0;
                end
                else if (op == wtalu_pkg::OP_SDIV)
                begin
                    r = sa / sb;
                end
                else
                begin
                    r = sa % sb;
                end
            end
            wtalu_pkg::OP_AND:  r = ua & ub;
            wtalu_pkg::OP_OR:   r = ua | ub;
            wtalu_pkg::OP_XOR:  r = ua ^ ub;
            wtalu_pkg::OP_SHL:  if (ub >= w) ok = 1'b0; else r = ua << ub;
            wtalu_pkg::OP_LSHR: if (ub >= w) ok = 1'b0; else r = ua >> ub;
            wtalu_pkg::OP_ASHR: if (ub >= w) ok = 1'b0; else r = sa >>> ub;
            wtalu_pkg::OP_EQ:   r = 64'(ua == ub);
            wtalu_pkg::OP_NE:   r = 64'(ua != ub);
            wtalu_pkg::OP_ULT:  r = 64'(ua < ub);
            wtalu_pkg::OP_ULE:  r = 64'(ua <= ub);
            wtalu_pkg::OP_UGT:  r = 64'(ua > ub);
            wtalu_pkg::OP_UGE:  r = 64'(ua >= ub);
            wtalu_pkg::OP_SLT:  r = 64'(sa < sb);
            wtalu_pkg::OP_SLE:  r = 64'(sa <= sb);
            wtalu_pkg::OP_SGT:  r = 64'(sa > sb);
            wtalu_pkg::OP_SGE:  r = 64'(sa >= sb);
            default: ok = 1'b0;
        endcase
        if (!ok)
        begin
            r = '0;
        end
        else if (op <= wtalu_pkg::OP_ASHR)
        begin
            r = zero_ext(r, w);
        end
        res.value   = r;
        res.fold_ok = ok;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    // Cycle counter and watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: stalls at random, and checks every result transfer against the
    // oldest pending expectation.
    always @(posedge clk)
    begin
        fold_result_t exp_res;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result %h", result_value));
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (result_value !== exp_res.value)
                    begin
                        report_mismatch($sformatf("result_value %h, expected %h",
                                                  result_value, exp_res.value));
                    end
                    if (foldable !== exp_res.fold_ok)
                    begin
                        report_mismatch($sformatf("foldable %b, expected %b",
                                                  foldable, exp_res.fold_ok));
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Presents one item and holds it until the transfer happens. The
    // expectation is queued at the edge that accepts the item.
    task automatic send_item(input logic [4:0] op, input logic [2:0] tcode,
                             input logic [63:0] a, input logic [63:0] b,
                             input fold_result_t exp_res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= op;
        type_code <= tcode;
        operand_a <= a;
        operand_b <= b;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        pending_results.insert(pending_results.size(), exp_res);
    endtask

    task automatic send_predicted(input logic [4:0] op, input logic [2:0] tcode,
                                  input logic [63:0] a, input logic [63:0] b);
        send_item(op, tcode, a, b, fold_operation(op, tcode, a, b));
    endtask

    // Lets the pipeline run dry before a register write.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Writes pointer_width over the register port: setup, then access.
    task automatic write_pointer_width(input logic [6:0] w);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(wtalu_pkg::REG_POINTER_WIDTH) << 2;
        pwdata  <= 32'(w);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ptr_width_shadow = w;
    endtask

    // Random operand with a bias towards the interesting corners.
    function automatic logic [63:0] random_operand();
        logic [63:0] v;
        case ($urandom_range(7))
            0: v = '0;
            1: v = ALL1;
            2: v = MIN64 >> $urandom_range(63);
            3: v = 64'($urandom_range(70));
            4: v = ~(64'($urandom_range(3)));
            default: v = {$urandom(), $urandom()};
        endcase
        return v;
    endfunction

    // Random item: mostly valid modes and types, a few unknown ones.
    task automatic send_random_item();
        logic [4:0] op;
        logic [2:0] tcode;
        op    = ($urandom_range(19) == 0) ? 5'($urandom_range(31)) :
                5'($urandom_range(wtalu_pkg::OP_SGE));
        tcode = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) :
                3'($urandom_range(wtalu_pkg::TYPE_PTR));
        send_predicted(op, tcode, random_operand(), random_operand());
    endtask

    directed_row_t directed_rows[$];

    function automatic directed_row_t row(input logic [4:0] op, input logic [2:0] tcode,
                                          input logic [63:0] a, input logic [63:0] b,
                                          input bit known = 0,
                                          input logic [63:0] kv = '0,
                                          input logic kf = 1'b1);
        directed_row_t r;
        r.op = op; r.tcode = tcode; r.a = a; r.b = b;
        r.has_known = known; r.known_value = kv; r.known_fold = kf;
        return r;
    endfunction

    // Appends one row to the end of the directed table.
    function automatic void add_row(input directed_row_t r);
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    initial
    begin
        fold_result_t exp_res;
        logic [6:0] ptr_settings[5];
        int unsigned idle_phase[4][2];
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = '0;
        type_code = '0;
        operand_a = '0;
        operand_b = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        ptr_width_shadow = 7'd64;
        mismatch_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        // Directed table. Refused folds and selected sums and comparisons are typed in;
        // the rest goes through the predictor.
        add_row(row(wtalu_pkg::OP_ADD, wtalu_pkg::TYPE_I64, ALL1, 64'd1, 1, 64'd0, 1'b1));
        add_row(row(wtalu_pkg::OP_ADD, wtalu_pkg::TYPE_I8, 64'hFF, 64'h01, 1, 64'd0, 1'b1));
        add_row(row(wtalu_pkg::OP_SUB, wtalu_pkg::TYPE_I1, 64'd0, 64'd1));
        add_row(row(wtalu_pkg::OP_MUL, wtalu_pkg::TYPE_I32, ALL1, ALL1));
        add_row(row(wtalu_pkg::OP_UDIV, wtalu_pkg::TYPE_I64, ALL1, 64'd0, 1, 64'd0, 1'b0));
        add_row(row(wtalu_pkg::OP_UREM, wtalu_pkg::TYPE_I16, 64'h1234, 64'h10000,
                    1, 64'd0, 1'b0));
        add_row(row(wtalu_pkg::OP_SDIV, wtalu_pkg::TYPE_I64, MIN64, ALL1, 1, 64'd0, 1'b0));
        add_row(row(wtalu_pkg::OP_SREM, wtalu_pkg::TYPE_I64, MIN64, ALL1, 1, 64'd0, 1'b0));
        add_row(row(wtalu_pkg::OP_SDIV, wtalu_pkg::TYPE_I8, 64'h80, 64'hFF));
        add_row(row(wtalu_pkg::OP_SREM, wtalu_pkg::TYPE_I32, 64'hFFFF_FFF9, 64'd2));
        add_row(row(wtalu_pkg::OP_SDIV, wtalu_pkg::TYPE_I16, 64'h8001, 64'd7));
        add_row(row(wtalu_pkg::OP_AND, wtalu_pkg::TYPE_I64, ALL1, 64'h5555_AAAA_5555_AAAA));
        add_row(row(wtalu_pkg::OP_OR, wtalu_pkg::TYPE_PTR, MIN64, 64'd1));
        add_row(row(wtalu_pkg::OP_XOR, wtalu_pkg::TYPE_I8, ALL1, 64'h0F));
        add_row(row(wtalu_pkg::OP_SHL, wtalu_pkg::TYPE_I64, 64'd1, 64'd63));
        add_row(row(wtalu_pkg::OP_SHL, wtalu_pkg::TYPE_I8, 64'd1, 64'd8, 1, 64'd0, 1'b0));
        add_row(row(wtalu_pkg::OP_LSHR, wtalu_pkg::TYPE_I32, ALL1, 64'd32, 1, 64'd0, 1'b0));
        add_row(row(wtalu_pkg::OP_ASHR, wtalu_pkg::TYPE_I16, 64'h8000, 64'd15));
        add_row(row(wtalu_pkg::OP_EQ, wtalu_pkg::TYPE_I8, 64'h1FF, 64'hFF, 1, 64'd1, 1'b1));
        add_row(row(wtalu_pkg::OP_NE, wtalu_pkg::TYPE_I1, 64'd2, 64'd0, 1, 64'd0, 1'b1));
        add_row(row(wtalu_pkg::OP_ULT, wtalu_pkg::TYPE_I64, 64'd0, ALL1, 1, 64'd1, 1'b1));
        add_row(row(wtalu_pkg::OP_ULE, wtalu_pkg::TYPE_I16, 64'hFFFF, 64'hFFFF));
        add_row(row(wtalu_pkg::OP_UGT, wtalu_pkg::TYPE_I32, 64'h8000_0000, 64'd1));
        add_row(row(wtalu_pkg::OP_UGE, 3'd7, 64'd5, 64'd6));
        add_row(row(wtalu_pkg::OP_SLT, wtalu_pkg::TYPE_I64, MIN64, 64'd0, 1, 64'd1, 1'b1));
        add_row(row(wtalu_pkg::OP_SLE, wtalu_pkg::TYPE_I8, 64'h80, 64'h7F));
        add_row(row(wtalu_pkg::OP_SGT, 3'd6, ALL1, 64'd0));
        add_row(row(wtalu_pkg::OP_SGE, wtalu_pkg::TYPE_I1, 64'd1, 64'd0));
        add_row(row(OP_UNKNOWN, wtalu_pkg::TYPE_I64, 64'd3, 64'd4, 1, 64'd0, 1'b0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the pointer width still at its reset value.
        recv_stall_pct = 0;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].has_known)
            begin
                exp_res.value   = directed_rows[i].known_value;
                exp_res.fold_ok = directed_rows[i].known_fold;
                send_item(directed_rows[i].op, directed_rows[i].tcode,
                          directed_rows[i].a, directed_rows[i].b, exp_res);
            end
            else
            begin
                send_predicted(directed_rows[i].op, directed_rows[i].tcode,
                               directed_rows[i].a, directed_rows[i].b);
            end
        end

        // Random part: each pointer width setting is run under each idling
        // phase. Widths 0 and above 64 must behave as 64.
        ptr_settings = '{7'd8, 7'd64, 7'd0, 7'd127, 7'd33};
        idle_phase = '{'{0, 0}, '{50, 0}, '{0, 50}, '{6, 6}};
        foreach (ptr_settings[s])
        begin
            drain_pipeline();
            write_pointer_width(ptr_settings[s]);
            foreach (idle_phase[p])
            begin
                send_idle_pct  = idle_phase[p][0];
                recv_stall_pct = idle_phase[p][1];
                repeat (100) send_random_item();
            end
        end

        // Let everything come out, then allow for the pipeline depth.
        in_valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 4) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
